// ----- rtl/planar_odometry_integrator_macros.svh -----
// Assertion helpers shared by the odometry integrator RTL.
// Both macros sample on the rising edge of clock and stay quiet while reset is high.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define POI_ASSERT_SAME(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);

// The condition must hold in the cycle after the trigger.
`define POI_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

// ----- rtl/poi_pkg.sv -----
package poi_pkg;

   // Fixed-point formats and iteration counts.
   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);
   localparam int TAB_IDX_W    = $clog2(TABLE_LEN);

   // Data widths.
   localparam int WORD_W    = 32;
   localparam int Q15_W     = 16;
   localparam int CX_W      = 34;
   localparam int CZ_W      = 33;
   localparam int MUL_W     = 34;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int RATE_SHIFT = 30;
   localparam int RATE_W    = PROD_W - RATE_SHIFT;
   localparam int CSR_IDX_W = 2;

   // CORDIC start value 1/K in Q4.30.
   localparam logic signed [CX_W-1:0] INV_GAIN = 34'sh0_26DD_3B6A;

   // Saturation limits for the Q1.15 quaternion terms.
   localparam logic signed [CX_W-1:0] Q15_MAX = 34'sd32767;
   localparam logic signed [CX_W-1:0] Q15_MIN = -34'sd32768;

   // Reset values of the registers and the pose.
   localparam logic signed [WORD_W-1:0] VEL_X_RESET    = 32'sd6554;
   localparam logic signed [WORD_W-1:0] VEL_Y_RESET    = -32'sd6554;
   localparam logic signed [WORD_W-1:0] YAW_RATE_RESET = 32'sd68356528;
   localparam logic signed [WORD_W-1:0] X_RESET        = 32'sd327680;
   localparam logic signed [WORD_W-1:0] Y_RESET        = -32'sd262144;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VEL_X    = 2'd0,
      CSR_VEL_Y    = 2'd1,
      CSR_YAW_RATE = 2'd2
   } csr_index_type;

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_ROT1   = 7'b0000010,
      ST_MUL    = 7'b0000100,
      ST_ACC    = 7'b0001000,
      ST_COMMIT = 7'b0010000,
      ST_ROT2   = 7'b0100000,
      ST_FIN    = 7'b1000000
   } state_type;

   // Multiplier passes, in the order they are issued.
   typedef enum logic [3:0] {
      OP_VX_COS = 4'd0,
      OP_VY_SIN = 4'd1,
      OP_RX_LO  = 4'd2,
      OP_RX_HI  = 4'd3,
      OP_VX_SIN = 4'd4,
      OP_VY_COS = 4'd5,
      OP_RY_LO  = 4'd6,
      OP_RY_HI  = 4'd7,
      OP_YAW    = 4'd8
   } op_type;

   // Arctangent of 2^-i in 2^-32 turn units.
   function automatic logic signed [CZ_W-1:0] atan_angle(input logic [TAB_IDX_W-1:0] idx);
      logic signed [CZ_W-1:0] a;
      unique case (idx)
         5'd0:    a = 33'sh0_2000_0000;
         5'd1:    a = 33'sh0_12E4_051E;
         5'd2:    a = 33'sh0_09FB_385B;
         5'd3:    a = 33'sh0_0511_11D4;
         5'd4:    a = 33'sh0_028B_0D43;
         5'd5:    a = 33'sh0_0145_D7E1;
         5'd6:    a = 33'sh0_00A2_F61E;
         5'd7:    a = 33'sh0_0051_7C55;
         5'd8:    a = 33'sh0_0028_BE53;
         5'd9:    a = 33'sh0_0014_5F2F;
         5'd10:   a = 33'sh0_000A_2F98;
         5'd11:   a = 33'sh0_0005_17CC;
         5'd12:   a = 33'sh0_0002_8BE6;
         5'd13:   a = 33'sh0_0001_45F3;
         5'd14:   a = 33'sh0_0000_A2F9;
         5'd15:   a = 33'sh0_0000_517D;
         5'd16:   a = 33'sh0_0000_28BE;
         5'd17:   a = 33'sh0_0000_145F;
         5'd18:   a = 33'sh0_0000_0A30;
         5'd19:   a = 33'sh0_0000_0518;
         5'd20:   a = 33'sh0_0000_028C;
         5'd21:   a = 33'sh0_0000_0146;
         5'd22:   a = 33'sh0_0000_00A3;
         5'd23:   a = 33'sh0_0000_0051;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ----- rtl/planar_odometry_integrator.sv -----
// Planar dead-reckoning pose integrator.
// Request channel (req_valid/req_ready/req_elapsed): one transaction per tick carrying the
// elapsed time since the previous tick in unsigned Q16.16 seconds.
// Response channel (rsp_*): one transaction per tick with the updated position (Q16.16),
// the heading as a 32-bit binary angle and the yaw quaternion terms z and w in Q1.15.
// Configuration port (csr_write/csr_index/csr_wdata): index 0 is vel_x, 1 is vel_y and
// 2 is yaw_rate; other indexes are ignored. Write only while no tick is in flight.
// Sequence: a tick runs a CORDIC over the old heading, nine passes of one shared 34x34
// multiplier (each pass a multiply state and an accumulate state), three pose updates and
// a second CORDIC over the half new heading. The response becomes valid in the same cycle
// as the block returns to idle and can take a new request; no new request is taken while
// a tick is in flight. The CORDIC iterations and the multiplier passes set the tick time.
// The response sits in an output register: the next request is accepted while it waits.
// If the receiver stalls, the following tick completes and then holds in its final state
// until the previous response has been taken.
// Reset (synchronous, active high) restores the velocity and yaw rate defaults, the
// position (5.0 m, -4.0 m) and a zero heading, and drops any response in flight.
`include "planar_odometry_integrator_macros.svh"

module planar_odometry_integrator (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic        [poi_pkg::WORD_W-1:0]    req_elapsed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [poi_pkg::WORD_W-1:0]    rsp_pos_x,
   output logic signed [poi_pkg::WORD_W-1:0]    rsp_pos_y,
   output logic        [poi_pkg::WORD_W-1:0]    rsp_heading_out,
   output logic signed [poi_pkg::Q15_W-1:0]     rsp_quat_z,
   output logic signed [poi_pkg::Q15_W-1:0]     rsp_quat_w,
   input  logic                                 csr_write,
   input  logic        [poi_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [poi_pkg::WORD_W-1:0]    csr_wdata
);
   import poi_pkg::*;

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CORDIC_STEPS - 1);
   localparam int HI_W = RATE_W - WORD_W;

   // Floor to Q1.15 with saturation.
   function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CX_W-1:0] v);
      logic signed [CX_W-1:0] r;
      r = v >>> 15;
      if (r > Q15_MAX) begin
         r = Q15_MAX;
      end else if (r < Q15_MIN) begin
         r = Q15_MIN;
      end
      return r[Q15_W-1:0];
   endfunction

   // Sequencer and control registers.
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        quad_ff, quad_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Configuration and pose.
   logic signed [WORD_W-1:0] vel_x_ff, vel_x_in;
   logic signed [WORD_W-1:0] vel_y_ff, vel_y_in;
   logic signed [WORD_W-1:0] yaw_ff, yaw_in;
   logic signed [WORD_W-1:0] x_ff, x_in;
   logic signed [WORD_W-1:0] y_ff, y_in;
   logic        [WORD_W-1:0] head_ff, head_in;

   // Datapath registers.
   logic        [WORD_W-1:0] dt_ff, dt_in;
   logic signed [CX_W-1:0]   cx_ff, cx_in;
   logic signed [CX_W-1:0]   cy_ff, cy_in;
   logic signed [CZ_W-1:0]   cz_ff, cz_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic signed [RATE_W-1:0] rate_ff, rate_in;

   // Response registers.
   logic signed [WORD_W-1:0] rsp_x_ff, rsp_x_in;
   logic signed [WORD_W-1:0] rsp_y_ff, rsp_y_in;
   logic        [WORD_W-1:0] rsp_h_ff, rsp_h_in;
   logic signed [Q15_W-1:0]  rsp_z_ff, rsp_z_in;
   logic signed [Q15_W-1:0]  rsp_w_ff, rsp_w_in;

   // Combinational helpers.
   logic signed [CX_W-1:0]   dx, dy, sn, cs;
   logic signed [CZ_W-1:0]   angle_step;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] acc_sum;
   logic        [WORD_W-1:0] delta;
   logic        [WORD_W-1:0] head_sum;
   logic        [WORD_W-1:0] half_head;
   logic                     req_take;

   assign req_take = req_valid && req_ready;

   // CORDIC micro-rotation terms, shared by both rotations.
   assign dx         = cy_ff >>> step_ff;
   assign dy         = cx_ff >>> step_ff;
   assign angle_step = atan_angle(TAB_IDX_W'(step_ff));

   // Quadrant correction of the rotated vector.
   always_comb begin
      unique case (quad_ff)
         2'd0: begin
            cs = cx_ff;
            sn = cy_ff;
         end
         2'd1: begin
            cs = -cy_ff;
            sn = cx_ff;
         end
         2'd2: begin
            cs = -cx_ff;
            sn = -cy_ff;
         end
         2'd3: begin
            cs = cy_ff;
            sn = -cx_ff;
         end
      endcase
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (op_ff)
         OP_VX_COS: begin
            mul_a = MUL_W'(vel_x_ff);
            mul_b = cs;
         end
         OP_VY_SIN: begin
            mul_a = MUL_W'(vel_y_ff);
            mul_b = sn;
         end
         OP_VX_SIN: begin
            mul_a = MUL_W'(vel_x_ff);
            mul_b = sn;
         end
         OP_VY_COS: begin
            mul_a = MUL_W'(vel_y_ff);
            mul_b = cs;
         end
         OP_RX_LO, OP_RY_LO: begin
            mul_a = {{(MUL_W - WORD_W){1'b0}}, rate_ff[WORD_W-1:0]};
            mul_b = {{(MUL_W - WORD_W){1'b0}}, dt_ff};
         end
         OP_RX_HI, OP_RY_HI: begin
            mul_a = {{(MUL_W - HI_W){rate_ff[RATE_W-1]}}, rate_ff[RATE_W-1:WORD_W]};
            mul_b = {{(MUL_W - WORD_W){1'b0}}, dt_ff};
         end
         OP_YAW: begin
            mul_a = MUL_W'(yaw_ff);
            mul_b = {{(MUL_W - WORD_W){1'b0}}, dt_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // Accumulator update for the current pass.
   always_comb begin
      unique case (op_ff)
         OP_VY_SIN:          acc_sum = acc_ff - prod_ff;
         OP_VY_COS:          acc_sum = acc_ff + prod_ff;
         OP_RX_HI, OP_RY_HI: acc_sum = acc_ff + (prod_ff <<< WORD_W);
         default:            acc_sum = prod_ff;
      endcase
   end

   // Step size taken from the scaled product, modulo one word.
   assign delta     = acc_ff[FRAC_BITS+WORD_W-1:FRAC_BITS];
   assign head_sum  = head_ff + delta;
   assign half_head = {1'b0, head_sum[WORD_W-1:1]};

   // Sequencer and datapath next state.
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      step_in      = step_ff;
      quad_in      = quad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      vel_x_in     = vel_x_ff;
      vel_y_in     = vel_y_ff;
      yaw_in       = yaw_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      head_in      = head_ff;
      dt_in        = dt_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      acc_in       = acc_ff;
      rate_in      = rate_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_h_in     = rsp_h_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_w_in     = rsp_w_ff;

      // Configuration writes; unknown indexes are dropped.
      if (csr_write) begin
         case (csr_index)
            CSR_VEL_X:    vel_x_in = csr_wdata;
            CSR_VEL_Y:    vel_y_in = csr_wdata;
            CSR_YAW_RATE: yaw_in   = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         // Take a tick and start rotating by the current heading.
         ST_IDLE: begin
            if (req_take) begin
               dt_in    = req_elapsed;
               quad_in  = head_ff[WORD_W-1:WORD_W-2];
               cx_in    = INV_GAIN;
               cy_in    = '0;
               cz_in    = {{(CZ_W - WORD_W + 2){1'b0}}, head_ff[WORD_W-3:0]};
               step_in  = '0;
               state_in = ST_ROT1;
            end
         end

         // One CORDIC micro-rotation per cycle for either rotation.
         ST_ROT1, ST_ROT2: begin
            if (!cz_ff[CZ_W-1]) begin
               cx_in = cx_ff - dx;
               cy_in = cy_ff + dy;
               cz_in = cz_ff - angle_step;
            end else begin
               cx_in = cx_ff + dx;
               cy_in = cy_ff - dy;
               cz_in = cz_ff + angle_step;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               if (state_ff == ST_ROT1) begin
                  op_in    = OP_VX_COS;
                  state_in = ST_MUL;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end

         // The product is registered in this cycle.
         ST_MUL: begin
            state_in = ST_ACC;
         end

         // Fold the product into the accumulator.
         ST_ACC: begin
            acc_in = acc_sum;
            if (op_ff == OP_VY_SIN || op_ff == OP_VY_COS) begin
               rate_in = acc_sum[PROD_W-1:RATE_SHIFT];
            end
            if (op_ff == OP_RX_HI || op_ff == OP_RY_HI || op_ff == OP_YAW) begin
               state_in = ST_COMMIT;
            end else begin
               op_in    = op_type'(op_ff + 4'd1);
               state_in = ST_MUL;
            end
         end

         // Add the scaled step to the pose; after the yaw pass, start the second rotation.
         ST_COMMIT: begin
            if (op_ff == OP_YAW) begin
               head_in  = head_sum;
               quad_in  = half_head[WORD_W-1:WORD_W-2];
               cx_in    = INV_GAIN;
               cy_in    = '0;
               cz_in    = {{(CZ_W - WORD_W + 2){1'b0}}, half_head[WORD_W-3:0]};
               step_in  = '0;
               state_in = ST_ROT2;
            end else begin
               if (op_ff == OP_RX_HI) begin
                  x_in = x_ff + $signed(delta);
               end else begin
                  y_in = y_ff + $signed(delta);
               end
               op_in    = op_type'(op_ff + 4'd1);
               state_in = ST_MUL;
            end
         end

         // Hand the result to the output register once it is free.
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_x_in     = x_ff;
               rsp_y_in     = y_ff;
               rsp_h_in     = head_ff;
               rsp_z_in     = to_q15(sn);
               rsp_w_in     = to_q15(cs);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state, configuration and pose, set to their defaults by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_VX_COS;
         step_ff      <= '0;
         quad_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         vel_x_ff     <= VEL_X_RESET;
         vel_y_ff     <= VEL_Y_RESET;
         yaw_ff       <= YAW_RATE_RESET;
         x_ff         <= X_RESET;
         y_ff         <= Y_RESET;
         head_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         step_ff      <= step_in;
         quad_ff      <= quad_in;
         rsp_valid_ff <= rsp_valid_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         yaw_ff       <= yaw_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         head_ff      <= head_in;
      end
   end

   // Datapath and response payload.
   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      rate_ff  <= rate_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
      rsp_h_ff <= rsp_h_in;
      rsp_z_ff <= rsp_z_in;
      rsp_w_ff <= rsp_w_in;
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_x_ff;
   assign rsp_pos_y       = rsp_y_ff;
   assign rsp_heading_out = rsp_h_ff;
   assign rsp_quat_z      = rsp_z_ff;
   assign rsp_quat_w      = rsp_w_ff;

   // Sequencer checks.
   `POI_ASSERT_NEXT(a_accept_starts_rotation, req_take, state_ff == ST_ROT1, "tick did not start the rotation")
   `POI_ASSERT_NEXT(a_mul_then_acc, state_ff == ST_MUL, state_ff == ST_ACC, "multiply not followed by accumulate")
   `POI_ASSERT_SAME(a_commit_pass, state_ff == ST_COMMIT, op_ff == OP_RX_HI || op_ff == OP_RY_HI || op_ff == OP_YAW, "pose update on a wrong pass")
   `POI_ASSERT_NEXT(a_fin_waits, state_ff == ST_FIN && rsp_valid && !rsp_ready, state_ff == ST_FIN && rsp_valid, "result overwrote a stalled response")

endmodule
